/* src/cba_pkg.sv */
`timescale 1ns / 1ps

package cba_pkg;

   // fixed field widths
   localparam int TOTAL_W = 13;
   localparam int IDX_W   = 12;
   localparam int NEED_W  = 7;
   localparam int WORD_W  = 32;
   localparam int SCAN_W  = 9;

   typedef logic [1:0] func_type;
   typedef logic [1:0] status_type;

   localparam func_type FN_MARK  = 2'd0;
   localparam func_type FN_QUERY = 2'd1;
   localparam func_type FN_ALLOC = 2'd2;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_RANGE = 2'd1;
   localparam status_type STAT_FAIL  = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MARK,
      S_QUERY,
      S_SINGLE,
      S_COUNT,
      S_TAIL,
      S_FETCH,
      S_LOAD,
      S_DRAIN
   } state_type;

endpackage

/* src/chunk_bitmap_allocator.sv */
`timescale 1ns / 1ps

// mark / query: word read (and written back for mark), result waits in S_SINGLE for a free output;
//   goes to S_SINGLE directly when the mark index is out of range or the allocate count is zero
//   or above the maximum. allocate: count pass over W = ceil(limit/32) words, one read per cycle,
//   then an emit pass that fetches, loads and drains each word visited, one id per response
// one transaction at a time; each pass reads 256 words at most
// reset: synchronous, then a pass clearing ceil(CHUNKS/32) words (128 by default) before requests
module chunk_bitmap_allocator #(
   parameter int CHUNKS   = 4096,
   parameter int MAX_NEED = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // chunk_index[11:0], need_count[18:12], exclude_index[30:19], tail_free[31]
   input  logic [31:0]                 req_tdata,
   // func[1:0]
   input  logic [1:0]                  req_tuser,
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status[1:0], chunk_id[13:2], has_id[14], is_used[15]
   output logic [15:0]                 rsp_tdata,
   output logic                        rsp_tlast,
   // total_chunks register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cba_pkg::TOTAL_W-1:0] csr_data
);

   import cba_pkg::*;

   // bitmap geometry
   localparam int NWORDS = (CHUNKS + WORD_W - 1) / WORD_W;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CAP    = (CHUNKS > 8191) ? 8191 : CHUNKS;
   localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

   // bitmap memory, one 32-bit word per address
   logic [WORD_W-1:0] mem_q [NWORDS];
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [WORD_W-1:0] rdata_ff;

   // control state
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [TOTAL_W-1:0] total_ff;

   // latched request
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [IDX_W-1:0]  excl_ff, excl_in;
   logic              tail_ff, tail_in;

   // scan bookkeeping
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [7:0]        rd_word_ff, rd_word_in;
   logic [NEED_W-1:0] cnt_ff, cnt_in;
   logic [NEED_W-1:0] out_cnt_ff, out_cnt_in;
   logic [WORD_W-1:0] mask_ff, mask_in;

   // pending single result
   status_type        sres_status_ff, sres_status_in;
   logic              sres_used_ff, sres_used_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_id_ff, rsp_id_in;
   logic              rsp_has_ff, rsp_has_in;
   logic              rsp_used_ff, rsp_used_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_load;
   logic              slot_free;

   // datapath helpers
   logic [TOTAL_W-1:0] limit;
   logic [5:0]         pop;
   logic [NEED_W:0]    cnt_sum;
   logic               more;
   logic [WORD_W-1:0]  low_bit;
   logic [4:0]         low_pos;
   logic               last_id;

   // request fields
   logic [IDX_W-1:0]  req_idx;
   logic [NEED_W-1:0] req_need;
   logic [IDX_W-1:0]  req_excl;
   logic              req_tail;
   func_type          req_func;

   // free chunks of one word: clear bit, below the limit, not the tail
   function automatic logic [WORD_W-1:0] free_mask(input logic [WORD_W-1:0] data,
                                                   input logic [7:0] word,
                                                   input logic [TOTAL_W-1:0] lim,
                                                   input logic [IDX_W-1:0] excl);
      logic [WORD_W-1:0] range_m;
      logic [WORD_W-1:0] excl_m;
      if (word < lim[12:5]) begin
         range_m = '1;
      end else if (word == lim[12:5]) begin
         range_m = (32'd1 << lim[4:0]) - 32'd1;
      end else begin
         range_m = '0;
      end
      excl_m = ({1'b0, excl[11:5]} == word) ? (32'd1 << excl[4:0]) : '0;
      return ~data & range_m & ~excl_m;
   endfunction

   // adder tree population count
   function automatic logic [5:0] popcount(input logic [WORD_W-1:0] v);
      logic [1:0] s1 [16];
      logic [2:0] s2 [8];
      logic [3:0] s3 [4];
      logic [4:0] s4 [2];
      for (int i = 0; i < 16; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      for (int i = 0; i < 8; i++)  s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
      for (int i = 0; i < 4; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
      for (int i = 0; i < 2; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
      return {1'b0, s4[0]} + {1'b0, s4[1]};
   endfunction

   function automatic logic [AW-1:0] word_addr(input logic [SCAN_W-1:0] w);
      logic [15:0] ext;
      ext = 16'(w);
      return ext[AW-1:0];
   endfunction

   assign req_idx  = req_tdata[11:0];
   assign req_need = req_tdata[18:12];
   assign req_excl = req_tdata[30:19];
   assign req_tail = req_tdata[31];
   assign req_func = req_tuser;

   assign limit     = (total_ff < TOTAL_W'(CAP)) ? total_ff : TOTAL_W'(CAP);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // count pass: free ids in the word that just came back
   assign pop     = popcount(free_mask(rdata_ff, rd_word_ff, limit, excl_ff));
   assign cnt_sum = {1'b0, cnt_ff} + (NEED_W + 1)'(pop);
   assign more    = {scan_ff, 5'b0} < {1'b0, limit};

   // emit pass: lowest free chunk of the held word
   assign low_bit = mask_ff & (~mask_ff + 32'd1);
   assign last_id = (out_cnt_ff + 7'd1) == need_ff;

   always_comb begin
      low_pos = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (low_bit[i]) low_pos = low_pos | 5'(i);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   // next state and outputs
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      rd_pend_in     = 1'b0;
      idx_in         = idx_ff;
      need_in        = need_ff;
      excl_in        = excl_ff;
      tail_in        = tail_ff;
      scan_in        = scan_ff;
      rd_word_in     = rd_word_ff;
      cnt_in         = cnt_ff;
      out_cnt_in     = out_cnt_ff;
      mask_in        = mask_ff;
      sres_status_in = sres_status_ff;
      sres_used_in   = sres_used_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = '0;
      out_load       = 1'b0;
      rsp_status_in  = STAT_OK;
      rsp_id_in      = '0;
      rsp_has_in     = 1'b0;
      rsp_used_in    = 1'b0;
      rsp_last_in    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_WORD) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               idx_in  = req_idx;
               need_in = req_need;
               excl_in = req_excl;
               tail_in = req_tail;
               case (req_func)
                  FN_MARK: begin
                     if ({1'b0, req_idx} >= limit) begin
                        sres_status_in = STAT_RANGE;
                        sres_used_in   = 1'b0;
                        state_in       = S_SINGLE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = word_addr(SCAN_W'(req_idx[11:5]));
                        state_in  = S_MARK;
                     end
                  end
                  FN_QUERY: begin
                     mem_re    = 1'b1;
                     mem_raddr = word_addr(SCAN_W'(req_idx[11:5]));
                     state_in  = S_QUERY;
                  end
                  FN_ALLOC: begin
                     sres_used_in = 1'b0;
                     if (req_need == '0) begin
                        sres_status_in = STAT_OK;
                        state_in       = S_SINGLE;
                     end else if (req_need > NEED_W'(MAX_NEED)) begin
                        sres_status_in = STAT_FAIL;
                        state_in       = S_SINGLE;
                     end else begin
                        cnt_in   = NEED_W'(req_tail);
                        scan_in  = '0;
                        state_in = S_COUNT;
                     end
                  end
                  default: begin
                     // undefined function: dropped without a result
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MARK: begin
            // read-modify-write of the word fetched in the previous cycle
            mem_we         = 1'b1;
            mem_waddr      = word_addr(SCAN_W'(idx_ff[11:5]));
            mem_wdata      = rdata_ff | (32'd1 << idx_ff[4:0]);
            sres_status_in = STAT_OK;
            sres_used_in   = 1'b0;
            state_in       = S_SINGLE;
         end
         S_QUERY: begin
            sres_status_in = STAT_OK;
            sres_used_in   = ({1'b0, idx_ff} < limit) && rdata_ff[idx_ff[4:0]];
            state_in       = S_SINGLE;
         end
         S_SINGLE: begin
            if (slot_free) begin
               out_load      = 1'b1;
               rsp_status_in = sres_status_ff;
               rsp_used_in   = sres_used_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_COUNT: begin
            if (cnt_ff >= need_ff ||
                (rd_pend_ff && cnt_sum >= {1'b0, need_ff})) begin
               scan_in    = '0;
               out_cnt_in = '0;
               state_in   = S_TAIL;
            end else if (!rd_pend_ff && !more) begin
               sres_status_in = STAT_FAIL;
               sres_used_in   = 1'b0;
               state_in       = S_SINGLE;
            end else begin
               if (rd_pend_ff) cnt_in = cnt_sum[NEED_W-1:0];
               if (more) begin
                  mem_re     = 1'b1;
                  mem_raddr  = word_addr(scan_ff);
                  rd_word_in = scan_ff[7:0];
                  scan_in    = scan_ff + 1'b1;
                  rd_pend_in = 1'b1;
               end
            end
         end
         S_TAIL: begin
            if (!tail_ff) begin
               state_in = S_FETCH;
            end else if (slot_free) begin
               out_load    = 1'b1;
               rsp_id_in   = excl_ff;
               rsp_has_in  = 1'b1;
               rsp_last_in = last_id;
               out_cnt_in  = out_cnt_ff + 7'd1;
               state_in    = last_id ? S_IDLE : S_FETCH;
            end
         end
         S_FETCH: begin
            mem_re    = 1'b1;
            mem_raddr = word_addr(scan_ff);
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            mask_in  = free_mask(rdata_ff, scan_ff[7:0], limit, excl_ff);
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (mask_ff == '0) begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_FETCH;
            end else if (slot_free) begin
               out_load    = 1'b1;
               rsp_id_in   = {scan_ff[6:0], low_pos};
               rsp_has_in  = 1'b1;
               rsp_last_in = last_id;
               out_cnt_in  = out_cnt_ff + 7'd1;
               mask_in     = mask_ff & ~low_bit;
               if (last_id) state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // bitmap memory ports
   always_ff @(posedge clock) begin
      if (mem_we) mem_q[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem_q[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= TOTAL_W'(4096);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) total_ff <= csr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      need_ff        <= need_in;
      excl_ff        <= excl_in;
      tail_ff        <= tail_in;
      scan_ff        <= scan_in;
      rd_word_ff     <= rd_word_in;
      cnt_ff         <= cnt_in;
      out_cnt_ff     <= out_cnt_in;
      mask_ff        <= mask_in;
      sres_status_ff <= sres_status_in;
      sres_used_ff   <= sres_used_in;
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_has_ff    <= rsp_has_in;
         rsp_used_ff   <= rsp_used_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_used_ff, rsp_has_ff, rsp_id_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* src/cba_chk.sv */
`timescale 1ns / 1ps

module cba_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   import cba_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // an allocated id always comes with ok status and no query answer
   a_id_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14] |-> rsp_tdata[1:0] == STAT_OK && !rsp_tdata[15])
      else $error("id transaction with bad status or query bit");

   // a result without an id is the only one of its request and carries id zero
   a_noid_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[14] |-> rsp_tlast && rsp_tdata[13:2] == '0)
      else $error("id-less transaction not last or nonzero id");

   // query answer only with ok status
   a_used_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |-> rsp_tdata[1:0] == STAT_OK)
      else $error("used flag with error status");

   // bitmap clearing keeps requests out right after reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

endmodule

bind chunk_bitmap_allocator cba_chk u_cba_chk (.*);
